@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/skat_pkg.sv @@
// ---------------------------------------------------------------------------
// skat_pkg
// types and constants of the sorted key accumulate table
// ---------------------------------------------------------------------------
`default_nettype none

package skat_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int DEFAULT_POS_WIDTH   = 32;
  localparam int WEIGHT_WIDTH        = 32;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;
  localparam status_t STATUS_SAT   = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE_NEW,
    ST_POP_RD,
    ST_FINISH
  } state_t;

  // result of the shared compare and add unit
  typedef struct packed {
    logic                           lt;
    logic                           eq;
    logic                           sat;
    logic signed [WEIGHT_WIDTH-1:0] sum;
  } alu_res_t;

endpackage

`default_nettype wire

@@ rtl/skat_ram.sv @@
// ---------------------------------------------------------------------------
// skat_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module skat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/skat_alu.sv @@
// ---------------------------------------------------------------------------
// skat_alu
// shared key compare and saturating q16.16 weight adder
// ---------------------------------------------------------------------------
`default_nettype none

module skat_alu #(
  parameter int KEY_WIDTH = skat_pkg::DEFAULT_POS_WIDTH
) (
  input  wire logic [KEY_WIDTH-1:0]                      key_a,
  input  wire logic [KEY_WIDTH-1:0]                      key_b,
  input  wire logic signed [skat_pkg::WEIGHT_WIDTH-1:0]  w_a,
  input  wire logic signed [skat_pkg::WEIGHT_WIDTH-1:0]  w_b,
  output skat_pkg::alu_res_t                             res
);

  localparam int WW = skat_pkg::WEIGHT_WIDTH;

  logic signed [WW:0] wide_sum;

  always_comb begin
    wide_sum = {w_a[WW-1], w_a} + {w_b[WW-1], w_b};
    res.lt   = key_a < key_b;
    res.eq   = key_a == key_b;
    // overflow when the two top bits of the wide sum disagree
    res.sat  = wide_sum[WW] != wide_sum[WW-1];
    if (res.sat) begin
      res.sum = wide_sum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      res.sum = wide_sum[WW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_key_accumulate_table_top.sv @@
// ---------------------------------------------------------------------------
// sorted_key_accumulate_table_top
// sorted interval table with insert-or-accumulate by start and pop of head
// ---------------------------------------------------------------------------
// sequence: a pop reads the head slot; an accumulate scans to the match and
//   writes the sum back; a new entry moves each entry above its place up one
//   slot, then is written; a drop on a full table ends after the scan
// throughput: one item at a time, next word taken once the result is loaded
//   into the output register; the single table ram sets the pace (one entry
//   compared per cycle while scanning, a read and a write per entry moved up)
// reset: synchronous, clears entry count, ring head and handshake state; table
//   contents are not cleared, only entries below the count are read
`default_nettype none

module sorted_key_accumulate_table_top #(
  parameter int TABLE_DEPTH = skat_pkg::DEFAULT_TABLE_DEPTH,
  parameter int POS_WIDTH   = skat_pkg::DEFAULT_POS_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  // input words
  input  wire logic s_tvalid,
  output logic      s_tready,
  // start_pos, end_pos, weight (from bit 0 up), zero filled to whole bytes
  input  wire logic [((2*POS_WIDTH+skat_pkg::WEIGHT_WIDTH+7)/8)*8-1:0] s_tdata,
  // kind
  input  wire logic s_tuser,
  // result words
  output logic      m_tvalid,
  input  wire logic m_tready,
  // head_start, head_end, head_weight, occupancy, status (from bit 0 up),
  // zero filled to whole bytes
  output logic [((2*POS_WIDTH+skat_pkg::WEIGHT_WIDTH+$clog2(TABLE_DEPTH+1)+2+7)/8)*8-1:0]
                    m_tdata,
  // head_valid
  output logic      m_tuser
);

  localparam int WW    = skat_pkg::WEIGHT_WIDTH;
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int EW    = 2*POS_WIDTH + WW;
  localparam int OUT_W = ((EW + CW + 2 + 7) / 8) * 8;

  // ring address of logical entry off, counted from the head slot
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW+1)'(TABLE_DEPTH)) begin
      s = s - (CW+1)'(TABLE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // sequencer and table bookkeeping
  skat_pkg::state_t state, state_next;
  logic [AW-1:0]    head, head_next;       // ring slot of the lowest start
  logic [CW-1:0]    count, count_next;     // entries held
  logic [CW-1:0]    ptr, ptr_next;         // scan index, then shift destination
  logic [CW-1:0]    ins_pos, ins_pos_next; // sorted place of a new entry

  // latched item
  logic [POS_WIDTH-1:0] item_start;
  logic [POS_WIDTH-1:0] item_end;
  logic signed [WW-1:0] item_weight;

  // result being built
  logic                 res_valid, res_valid_next;
  logic [POS_WIDTH-1:0] res_start, res_start_next;
  logic [POS_WIDTH-1:0] res_end, res_end_next;
  logic [WW-1:0]        res_weight, res_weight_next;
  skat_pkg::status_t    res_status, res_status_next;

  // output register
  logic                 out_hv;
  logic [POS_WIDTH-1:0] out_hs;
  logic [POS_WIDTH-1:0] out_he;
  logic [WW-1:0]        out_hw;
  logic [CW-1:0]        out_occ;
  skat_pkg::status_t    out_status;
  logic                 out_load;

  // table ram, entry packed as weight, end, start from the top down
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [POS_WIDTH-1:0] rd_start;
  logic [POS_WIDTH-1:0] rd_end;
  logic signed [WW-1:0] rd_weight;

  skat_pkg::alu_res_t alu_res;

  logic in_accept;

  // terms for the checks at the end
  logic in_shift;
  logic out_full_drop;
  logic out_empty_pop;

  assign rd_start  = ram_rdata[POS_WIDTH-1:0];
  assign rd_end    = ram_rdata[2*POS_WIDTH-1:POS_WIDTH];
  assign rd_weight = ram_rdata[EW-1:2*POS_WIDTH];

  assign s_tready  = (state == skat_pkg::ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  assign m_tuser = out_hv;
  assign m_tdata = OUT_W'({out_status, out_occ, out_hw, out_he, out_hs});

  skat_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one compare and add unit serves the scan and the accumulate
  skat_alu #(
    .KEY_WIDTH (POS_WIDTH)
  ) u_alu (
    .key_a (rd_start),
    .key_b (item_start),
    .w_a   (rd_weight),
    .w_b   (item_weight),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= skat_pkg::ST_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    ins_pos    <= ins_pos_next;
    res_valid  <= res_valid_next;
    res_start  <= res_start_next;
    res_end    <= res_end_next;
    res_weight <= res_weight_next;
    res_status <= res_status_next;
    if (in_accept) begin
      item_start  <= s_tdata[POS_WIDTH-1:0];
      item_end    <= s_tdata[2*POS_WIDTH-1:POS_WIDTH];
      item_weight <= s_tdata[EW-1:2*POS_WIDTH];
    end
    if (out_load) begin
      out_hv     <= res_valid;
      out_hs     <= res_start;
      out_he     <= res_end;
      out_hw     <= res_weight;
      out_occ    <= count;
      out_status <= res_status;
    end
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    ptr_next        = ptr;
    ins_pos_next    = ins_pos;
    res_valid_next  = res_valid;
    res_start_next  = res_start;
    res_end_next    = res_end;
    res_weight_next = res_weight;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = phys(head, ptr);
    ram_wdata       = ram_rdata;
    ram_raddr       = head;
    out_load        = 1'b0;

    case (state)
      skat_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          res_valid_next  = 1'b0;
          res_start_next  = '0;
          res_end_next    = '0;
          res_weight_next = '0;
          res_status_next = skat_pkg::STATUS_OK;
          ptr_next        = '0;
          ins_pos_next    = '0;
          // head slot is read now for both scan and pop
          ram_raddr       = head;
          if (s_tuser == skat_pkg::KIND_POP) begin
            if (count == '0) begin
              res_status_next = skat_pkg::STATUS_EMPTY;
              state_next      = skat_pkg::ST_FINISH;
            end else begin
              state_next = skat_pkg::ST_POP_RD;
            end
          end else if (count == '0) begin
            state_next = skat_pkg::ST_PLACE;
          end else begin
            state_next = skat_pkg::ST_SCAN;
          end
        end
      end

      // entry ptr is on the ram output
      skat_pkg::ST_SCAN: begin
        if (alu_res.eq) begin
          ram_we          = 1'b1;
          ram_waddr       = phys(head, ptr);
          ram_wdata       = {alu_res.sum, rd_end, rd_start};
          res_status_next = alu_res.sat ? skat_pkg::STATUS_SAT : skat_pkg::STATUS_OK;
          state_next      = skat_pkg::ST_FINISH;
        end else if (alu_res.lt) begin
          if (ptr + CW'(1) == count) begin
            ins_pos_next = count;
            state_next   = skat_pkg::ST_PLACE;
          end else begin
            ptr_next  = ptr + CW'(1);
            ram_raddr = phys(head, ptr + CW'(1));
          end
        end else begin
          ins_pos_next = ptr;
          state_next   = skat_pkg::ST_PLACE;
        end
      end

      skat_pkg::ST_PLACE: begin
        if (count == CW'(TABLE_DEPTH)) begin
          res_status_next = skat_pkg::STATUS_FULL;
          state_next      = skat_pkg::ST_FINISH;
        end else begin
          ptr_next = count;
          if (count == ins_pos) begin
            state_next = skat_pkg::ST_WRITE_NEW;
          end else begin
            state_next = skat_pkg::ST_SHIFT_RD;
          end
        end
      end

      // move entry ptr-1 up to ptr
      skat_pkg::ST_SHIFT_RD: begin
        ram_raddr  = phys(head, ptr - CW'(1));
        state_next = skat_pkg::ST_SHIFT_WR;
      end

      skat_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head, ptr);
        ram_wdata = ram_rdata;
        ptr_next  = ptr - CW'(1);
        if (ptr - CW'(1) == ins_pos) begin
          state_next = skat_pkg::ST_WRITE_NEW;
        end else begin
          state_next = skat_pkg::ST_SHIFT_RD;
        end
      end

      skat_pkg::ST_WRITE_NEW: begin
        ram_we     = 1'b1;
        ram_waddr  = phys(head, ins_pos);
        ram_wdata  = {item_weight, item_end, item_start};
        count_next = count + CW'(1);
        state_next = skat_pkg::ST_FINISH;
      end

      skat_pkg::ST_POP_RD: begin
        res_valid_next  = 1'b1;
        res_start_next  = rd_start;
        res_end_next    = rd_end;
        res_weight_next = rd_weight;
        head_next       = phys(head, CW'(1));
        count_next      = count - CW'(1);
        state_next      = skat_pkg::ST_FINISH;
      end

      // hand the result to the output register once it is free
      skat_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = skat_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = skat_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_shift      = (state == skat_pkg::ST_SHIFT_RD) || (state == skat_pkg::ST_SHIFT_WR);
  assign out_full_drop = m_tvalid && (out_status == skat_pkg::STATUS_FULL);
  assign out_empty_pop = m_tvalid && (out_status == skat_pkg::STATUS_EMPTY);

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(TABLE_DEPTH), "entry count above table depth")
  `ASSERT_IMPL(a_scan_in_range, state == skat_pkg::ST_SCAN, ptr < count, "scan past last entry")
  `ASSERT_IMPL(a_shift_window, in_shift, (ptr > ins_pos) && (ptr <= count), "shift out of window")
  `ASSERT_IMPL(a_full_occ, out_full_drop, (out_occ == CW'(TABLE_DEPTH)) && !out_hv, "bad full drop")
  `ASSERT_IMPL(a_empty_pop, out_empty_pop, (out_occ == '0) && !out_hv, "bad empty pop result")

endmodule

`default_nettype wire

@@ verif/sorted_key_accumulate_table_top_tb.sv @@
// ---------------------------------------------------------------------------
// sorted_key_accumulate_table_top_tb
// self-checking bench: a directed opening (empty pop, key and weight extremes,
// saturation at both bounds, drain) then random insert/accumulate/pop traffic
// in fill, mixed and drain phases, checked word by word against a shadow table
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_key_accumulate_table_top_tb;

  localparam int DEPTH    = skat_pkg::DEFAULT_TABLE_DEPTH;
  localparam int PW       = skat_pkg::DEFAULT_POS_WIDTH;
  localparam int WW       = skat_pkg::WEIGHT_WIDTH;
  localparam int OCC_W    = $clog2(DEPTH + 1);
  localparam int IN_W     = ((2*PW + WW + 7) / 8) * 8;
  localparam int OUT_W    = ((2*PW + WW + OCC_W + 2 + 7) / 8) * 8;
  localparam int OCC_LSB  = 2*PW + WW;
  localparam int STAT_LSB = OCC_LSB + OCC_W;

  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 7;
  localparam int TAIL_ITEMS   = 50;    // no idling once this few are left
  localparam int HOLD_AFTER   = 150;   // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int END_SETTLE   = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int POOL_MAX     = 48;

  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;

  typedef struct {
    logic              kind;
    logic [PW-1:0]     start_pos;
    logic [PW-1:0]     end_pos;
    logic signed [31:0] weight;
    bit                idle_ok;
  } table_op_t;

  typedef struct {
    logic              head_valid;
    logic [PW-1:0]     head_start;
    logic [PW-1:0]     head_end;
    logic signed [31:0] head_weight;
    logic [OCC_W-1:0]  occupancy;
    skat_pkg::status_t status;
  } head_word_t;

  logic             clk;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             s_tuser  = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;

  sorted_key_accumulate_table_top #(
    .TABLE_DEPTH(DEPTH),
    .POS_WIDTH  (PW)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // start_pos, end_pos, weight from bit 0 up
    .s_tuser (s_tuser),   // kind
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // head_start, head_end, head_weight, occupancy, status
    .m_tuser (m_tuser)    // head_valid
  );

  // period of 2
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // shadow copy of the table
  logic [PW-1:0]      shadow_start [DEPTH];
  logic [PW-1:0]      shadow_end   [DEPTH];
  logic signed [31:0] shadow_wt    [DEPTH];
  int                 shadow_cnt = 0;

  table_op_t     ops_to_send[$];
  head_word_t    head_words_due[$];
  logic [PW-1:0] key_pool[$];

  int   err_cnt      = 0;
  int   results_seen = 0;
  int   cycle_cnt    = 0;
  logic in_taken     = 1'b0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   rx_pct       = 0;
  int   rx_mode_cnt  = 0;
  logic hold_on      = 1'b0;
  logic hold_done    = 1'b0;
  int   hold_left    = 0;

  // apply one word to the shadow table and return the result word it causes
  function automatic head_word_t table_update(table_op_t op);
    head_word_t r;
    int         idx;
    int         k;
    longint     sum;
    r.head_valid  = 1'b0;
    r.head_start  = '0;
    r.head_end    = '0;
    r.head_weight = '0;
    r.status      = skat_pkg::STATUS_OK;
    if (op.kind == skat_pkg::KIND_POP) begin
      if (shadow_cnt == 0) begin
        r.status = skat_pkg::STATUS_EMPTY;
      end else begin
        r.head_valid  = 1'b1;
        r.head_start  = shadow_start[0];
        r.head_end    = shadow_end[0];
        r.head_weight = shadow_wt[0];
        for (k = 0; k < shadow_cnt - 1; k++) begin
          shadow_start[k] = shadow_start[k+1];
          shadow_end[k]   = shadow_end[k+1];
          shadow_wt[k]    = shadow_wt[k+1];
        end
        shadow_cnt--;
      end
    end else begin
      idx = 0;
      while (idx < shadow_cnt && shadow_start[idx] < op.start_pos)
        idx++;
      if (idx < shadow_cnt && shadow_start[idx] == op.start_pos) begin
        // matching start: accumulate, end kept, clamp at the q16.16 bounds
        sum = longint'(shadow_wt[idx]) + longint'(op.weight);
        if (sum > W_MAX) begin
          shadow_wt[idx] = W_MAX[31:0];
          r.status       = skat_pkg::STATUS_SAT;
        end else if (sum < W_MIN) begin
          shadow_wt[idx] = W_MIN[31:0];
          r.status       = skat_pkg::STATUS_SAT;
        end else begin
          shadow_wt[idx] = sum[31:0];
        end
      end else if (shadow_cnt >= DEPTH) begin
        r.status = skat_pkg::STATUS_FULL;
      end else begin
        for (k = shadow_cnt; k > idx; k--) begin
          shadow_start[k] = shadow_start[k-1];
          shadow_end[k]   = shadow_end[k-1];
          shadow_wt[k]    = shadow_wt[k-1];
        end
        shadow_start[idx] = op.start_pos;
        shadow_end[idx]   = op.end_pos;
        shadow_wt[idx]    = op.weight;
        shadow_cnt++;
      end
    end
    r.occupancy = shadow_cnt[OCC_W-1:0];
    return r;
  endfunction

  task automatic flag_error(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  // stimulus helpers
  function automatic void push_op(logic kind, logic [PW-1:0] st, logic [PW-1:0] en,
                                  logic [31:0] wt, bit idle_ok);
    table_op_t op;
    op.kind      = kind;
    op.start_pos = st;
    op.end_pos   = en;
    op.weight    = wt;
    op.idle_ok   = idle_ok;
    ops_to_send.push_back(op);
    if (kind == skat_pkg::KIND_INSERT) begin
      key_pool.push_back(st);
      if (key_pool.size() > POOL_MAX)
        void'(key_pool.pop_front());
    end
  endfunction

  // fresh wide keys, recent keys (reuse_pct percent) to hit accumulate, some tiny keys
  function automatic logic [PW-1:0] pick_key(int reuse_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < reuse_pct && key_pool.size() != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (roll < reuse_pct + 15)
      return PW'($urandom_range(0, 31));
    return PW'($urandom);
  endfunction

  function automatic logic [31:0] pick_weight();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2, 3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin : stim
    int  ph;
    int  n;
    int  pop_pct;
    int  reuse_pct;
    bit  idle_ok;

    // directed opening
    push_op(skat_pkg::KIND_POP,    '0, '0, 32'h0, 1'b1); // empty pop
    push_op(skat_pkg::KIND_INSERT, 32'h8000_0000, 32'h5555_5555, 32'h0,         1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    // saturate high and low, end must stay unchanged; then an accumulate and new keys
    push_op(skat_pkg::KIND_INSERT, 32'h0000_0000, 32'hAAAA_AAAA, 32'h0000_0001, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'h8000_0000, 32'h0F0F_0F0F, 32'h0001_8000, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'h8000_0000, 32'hF0F0_F0F0, 32'hFFFF_C000, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'h0000_0100, 32'h0000_0200, 32'h0002_0000, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b1);
    // max plus min lands on -1 with no clamp
    push_op(skat_pkg::KIND_INSERT, 32'h0000_0000, 32'h0,         32'h8000_0000, 1'b1);
    // reach the upper bound exactly, then step past it
    push_op(skat_pkg::KIND_INSERT, 32'h0000_0005, 32'h0000_0009, 32'h7FFF_0000, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'h0000_0005, 32'h0,         32'h0000_FFFF, 1'b1);
    push_op(skat_pkg::KIND_INSERT, 32'h0000_0005, 32'h0,         32'h0000_0001, 1'b1);
    for (n = 0; n < 7; n++)
      push_op(skat_pkg::KIND_POP, PW'($urandom), PW'($urandom), $urandom, 1'b1);

    // random phases: fill in phases 0, 1 and 5 to hit the full table, drain in 3 and 4 to empty it
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0, 1, 5: begin pop_pct = 8;  reuse_pct = 25; end
        3, 4:    begin pop_pct = 80; reuse_pct = 40; end
        default: begin pop_pct = 40; reuse_pct = 50; end
      endcase
      idle_ok = (ph != 2 && ph != 5);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < pop_pct)
          push_op(skat_pkg::KIND_POP, PW'($urandom), PW'($urandom), $urandom, idle_ok);
        else
          push_op(skat_pkg::KIND_INSERT, pick_key(reuse_pct), PW'($urandom),
                  pick_weight(), idle_ok);
      end
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || s_tvalid || head_words_due.size() != 0)
      @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // input driver, changes on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : in_drv
    table_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (ops_to_send.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (ops_to_send.size() >= TAIL_ITEMS && !hold_on && ops_to_send[0].idle_ok
                   && $urandom_range(0, 7) == 0) begin
        // idle burst: this slot and then gap_left more, drawn at random
        s_tvalid <= 1'b0;
        gap_left <= $urandom_range(0, 13);
      end else begin
        op = ops_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= op.kind;
        s_tdata  <= {op.weight, op.end_pos, op.start_pos};
      end
    end
  end

  // ---------------------------------------------------------------------
  // result receiver, random stall bursts in modes that change as rx_mode_cnt wraps
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_cnt == 63) begin
        case ($urandom_range(0, 2))
          0:       rx_pct <= 0;
          1:       rx_pct <= 15;
          default: rx_pct <= 50;
        endcase
      end
      rx_mode_cnt <= (rx_mode_cnt + 1) % 64;
      if (hold_on) begin
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (ops_to_send.size() >= TAIL_ITEMS && $urandom_range(0, 99) < rx_pct) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 13);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one long hold-off on the result side so the block backs up its input
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_on) begin
        if (hold_left == 0)
          hold_on <= 1'b0;
        else
          hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_on   <= 1'b1;
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: predict on input word, check on result word, rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : mon
    table_op_t  op;
    head_word_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        op.kind      = s_tuser;
        op.start_pos = s_tdata[PW-1:0];
        op.end_pos   = s_tdata[2*PW-1:PW];
        op.weight    = s_tdata[2*PW +: 32];
        op.idle_ok   = 1'b0;
        head_words_due.push_back(table_update(op));
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (head_words_due.size() == 0) begin
          flag_error($sformatf("result word with none due, data %h", m_tdata));
        end else begin
          want = head_words_due.pop_front();
          if (m_tuser !== want.head_valid)
            flag_error($sformatf("head_valid %b, wanted %b", m_tuser, want.head_valid));
          if (m_tdata[PW-1:0] !== want.head_start)
            flag_error($sformatf("head_start %h, wanted %h", m_tdata[PW-1:0],
                                 want.head_start));
          if (m_tdata[2*PW-1:PW] !== want.head_end)
            flag_error($sformatf("head_end %h, wanted %h", m_tdata[2*PW-1:PW],
                                 want.head_end));
          if (m_tdata[2*PW +: 32] !== want.head_weight)
            flag_error($sformatf("head_weight %h, wanted %h", m_tdata[2*PW +: 32],
                                 want.head_weight));
          if (m_tdata[OCC_LSB +: OCC_W] !== want.occupancy)
            flag_error($sformatf("occupancy %0d, wanted %0d", m_tdata[OCC_LSB +: OCC_W],
                                 want.occupancy));
          if (m_tdata[STAT_LSB +: 2] !== want.status)
            flag_error($sformatf("status %0d, wanted %0d", m_tdata[STAT_LSB +: 2],
                                 want.status));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
